// File: src/ske_pkg.sv
// Package for the sorted key set engine: codes, cell command type and shared defaults.
// Used by every module under src; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ske_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int KEY_BITS_DEF = 48;

    localparam int ACTION_W = 2;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 11;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RENAME = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_DUP      = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_ZERO     = 3'd4;

    // What a cell does with its key at the commit edge.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_FROM_LEFT,
        OP_FROM_RIGHT,
        OP_LOAD
    } cell_op_t;

    // Compare results a cell captures when an item is accepted.
    typedef struct packed {
        logic lt_key;
        logic eq_key;
        logic lt_new;
        logic eq_new;
    } cell_flags_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ENCODE,
        S_APPLY
    } ske_state_t;

endpackage

`default_nettype wire

// File: src/sorted_key_set_engine_top.sv
// Top level of the sorted key set engine: control sequencer, row of key cells
// and the two lower-bound encoders. Depends on ske_pkg, ske_cell, ske_encode.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// An item (action, key, new_key) is taken at a rising edge where start is high
// and busy is low. The block is then busy through the encode and apply steps.
// Take: every cell compares its key with key and new_key as the item is taken.
// Encode: the flags of all cells are encoded into two insert points and hits.
// Apply: the status is decided and, if the set changes, the row shifts by one
// place toward or away from the affected index; an insert or rename loads its
// new key in one cell. The result (status, position, entry_total) shows with
// done high for exactly one cycle, starting the cycle after the commit edge;
// the receiver cannot stall. busy is already low in that cycle, so a new item
// can be taken while done is high, but not before the last one is through.
// Reset empties the set at once (the fill count goes to zero); cell keys are
// only read below the fill count and need no clearing.
module sorted_key_set_engine_top #(
    parameter int CAPACITY = ske_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = ske_pkg::KEY_BITS_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire  [ske_pkg::ACTION_W-1:0] action,
    input  wire  [KEY_BITS-1:0]          key,
    input  wire  [KEY_BITS-1:0]          new_key,
    output logic                         done,
    output logic [ske_pkg::STATUS_W-1:0] status,
    output logic [ske_pkg::POS_W-1:0]    position,
    output logic [ske_pkg::POS_W-1:0]    entry_total
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    ske_pkg::ske_state_t state_reg;
    ske_pkg::ske_state_t state_next;

    logic                          sample;
    logic [ske_pkg::ACTION_W-1:0]  act_reg;
    logic [KEY_BITS-1:0]           key_reg;
    logic [KEY_BITS-1:0]           nkey_reg;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic [CNT_W-1:0]              posk_reg;
    logic [CNT_W-1:0]              posn_reg;
    logic                          hitk_reg;
    logic                          hitn_reg;

    logic [CNT_W-1:0]              posk_enc;
    logic [CNT_W-1:0]              posn_enc;
    logic                          hitk_enc;
    logic                          hitn_enc;

    logic                          done_reg;
    logic [ske_pkg::STATUS_W-1:0]  status_reg;
    logic [ske_pkg::STATUS_W-1:0]  status_next;
    logic [CNT_W-1:0]              pos_reg;
    logic [CNT_W-1:0]              pos_next;

    // Row move command for the commit edge.
    logic                          move_en;
    logic                          move_up;
    logic [CNT_W-1:0]              move_lo;
    logic [CNT_W-1:0]              move_hi;
    logic                          load_en;
    logic [CNT_W-1:0]              load_idx;
    logic [KEY_BITS-1:0]           load_key;
    logic [CNT_W-1:0]              rename_idx;

    logic [KEY_BITS-1:0]           cell_key [CAPACITY];
    ske_pkg::cell_flags_t          cell_flags [CAPACITY];
    logic [CAPACITY-1:0]           ltk_vec;
    logic [CAPACITY-1:0]           eqk_vec;
    logic [CAPACITY-1:0]           ltn_vec;
    logic [CAPACITY-1:0]           eqn_vec;

    assign busy   = state_reg != ske_pkg::S_IDLE;
    assign sample = start && !busy;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            ske_pkg::cell_op_t   op;
            logic [KEY_BITS-1:0] left_key;
            logic [KEY_BITS-1:0] right_key;
            logic                in_range;

            assign in_range = (CNT_W'(g) >= move_lo) && (CNT_W'(g) < move_hi);

            always_comb
            begin
                op = ske_pkg::OP_HOLD;
                if (state_reg == ske_pkg::S_APPLY)
                begin
                    if (load_en && (CNT_W'(g) == load_idx))
                    begin
                        op = ske_pkg::OP_LOAD;
                    end
                    else if (move_en && in_range)
                    begin
                        op = move_up ? ske_pkg::OP_FROM_LEFT : ske_pkg::OP_FROM_RIGHT;
                    end
                end
            end

            if (g == 0)
            begin : g_first
                assign left_key = load_key;
            end
            else
            begin : g_mid_l
                assign left_key = cell_key[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_last
                assign right_key = load_key;
            end
            else
            begin : g_mid_r
                assign right_key = cell_key[g+1];
            end

            ske_cell #(
                .IDX      (g),
                .KEY_BITS (KEY_BITS),
                .CNT_W    (CNT_W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .sample    (sample),
                .count     (count_reg),
                .cmp_key   (key),
                .cmp_new   (new_key),
                .op        (op),
                .left_key  (left_key),
                .right_key (right_key),
                .load_key  (load_key),
                .key_out   (cell_key[g]),
                .flags     (cell_flags[g])
            );

            assign ltk_vec[g] = cell_flags[g].lt_key;
            assign eqk_vec[g] = cell_flags[g].eq_key;
            assign ltn_vec[g] = cell_flags[g].lt_new;
            assign eqn_vec[g] = cell_flags[g].eq_new;
        end
    endgenerate

    ske_encode #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_enc_key (
        .lt_vec (ltk_vec),
        .eq_vec (eqk_vec),
        .pos    (posk_enc),
        .hit    (hitk_enc)
    );

    ske_encode #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_enc_new (
        .lt_vec (ltn_vec),
        .eq_vec (eqn_vec),
        .pos    (posn_enc),
        .hit    (hitn_enc)
    );

    // After the old key leaves, a target above it lands one place lower.
    assign rename_idx = (posn_reg > posk_reg) ? (posn_reg - CNT_W'(1)) : posn_reg;

    // Decision for the item in the commit cycle.
    always_comb
    begin
        status_next = ske_pkg::STAT_OK;
        pos_next    = posk_reg;
        count_next  = count_reg;
        move_en     = 1'b0;
        move_up     = 1'b0;
        move_lo     = '0;
        move_hi     = '0;
        load_en     = 1'b0;
        load_idx    = posk_reg;
        load_key    = key_reg;
        if (key_reg == '0)
        begin
            status_next = ske_pkg::STAT_ZERO;
            pos_next    = '0;
        end
        else
        begin
            case (act_reg)
                ske_pkg::ACT_INSERT:
                begin
                    if (hitk_reg)
                    begin
                        status_next = ske_pkg::STAT_DUP;
                    end
                    else if (count_reg >= CNT_W'(CAPACITY))
                    begin
                        status_next = ske_pkg::STAT_FULL;
                    end
                    else
                    begin
                        move_en    = 1'b1;
                        move_up    = 1'b1;
                        move_lo    = posk_reg + CNT_W'(1);
                        move_hi    = CNT_W'(CAPACITY);
                        load_en    = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                ske_pkg::ACT_RENAME:
                begin
                    if (!hitk_reg)
                    begin
                        status_next = ske_pkg::STAT_NOTFOUND;
                    end
                    else if (nkey_reg == key_reg)
                    begin
                        status_next = ske_pkg::STAT_OK;
                    end
                    else if (nkey_reg == '0)
                    begin
                        status_next = ske_pkg::STAT_ZERO;
                    end
                    else if (hitn_reg)
                    begin
                        status_next = ske_pkg::STAT_DUP;
                        pos_next    = posn_reg;
                    end
                    else
                    begin
                        pos_next = rename_idx;
                        move_en  = 1'b1;
                        load_en  = 1'b1;
                        load_idx = rename_idx;
                        load_key = nkey_reg;
                        if (posn_reg > posk_reg)
                        begin
                            // Entries between the old and new place move down.
                            move_up = 1'b0;
                            move_lo = posk_reg;
                            move_hi = rename_idx;
                        end
                        else
                        begin
                            move_up = 1'b1;
                            move_lo = rename_idx + CNT_W'(1);
                            move_hi = posk_reg + CNT_W'(1);
                        end
                    end
                end
                default:
                begin
                    if (hitk_reg)
                    begin
                        move_en    = 1'b1;
                        move_up    = 1'b0;
                        move_lo    = posk_reg;
                        move_hi    = CNT_W'(CAPACITY - 1);
                        count_next = count_reg - CNT_W'(1);
                    end
                    else
                    begin
                        status_next = ske_pkg::STAT_NOTFOUND;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ske_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = ske_pkg::S_ENCODE;
                end
            end
            ske_pkg::S_ENCODE: state_next = ske_pkg::S_APPLY;
            ske_pkg::S_APPLY:  state_next = ske_pkg::S_IDLE;
            default:           state_next = ske_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ske_pkg::S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= state_reg == ske_pkg::S_APPLY;
            if (state_reg == ske_pkg::S_APPLY)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample)
        begin
            act_reg  <= action;
            key_reg  <= key;
            nkey_reg <= new_key;
        end
        if (state_reg == ske_pkg::S_ENCODE)
        begin
            posk_reg <= posk_enc;
            posn_reg <= posn_enc;
            hitk_reg <= hitk_enc;
            hitn_reg <= hitn_enc;
        end
        if (state_reg == ske_pkg::S_APPLY)
        begin
            status_reg <= status_next;
            pos_reg    <= pos_next;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign position    = ske_pkg::POS_W'(pos_reg);
    assign entry_total = ske_pkg::POS_W'(count_reg);

`ifndef SYNTH
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_done_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ske_pkg::S_APPLY))
        else $error("result strobe without a commit cycle");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ske_pkg::STAT_FULL |-> count_reg == CNT_W'(CAPACITY))
        else $error("table full reported below capacity");
`endif

endmodule

`default_nettype wire

// File: src/ske_cell.sv
// One storage cell of the sorted key row: holds a key, compares it with the
// incoming keys and moves it to or from a neighbor. Depends on ske_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ske_cell #(
    parameter int IDX      = 0,
    parameter int KEY_BITS = ske_pkg::KEY_BITS_DEF,
    parameter int CNT_W    = 11
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      sample,
    input  wire  [CNT_W-1:0]         count,
    input  wire  [KEY_BITS-1:0]      cmp_key,
    input  wire  [KEY_BITS-1:0]      cmp_new,
    input  ske_pkg::cell_op_t        op,
    input  wire  [KEY_BITS-1:0]      left_key,
    input  wire  [KEY_BITS-1:0]      right_key,
    input  wire  [KEY_BITS-1:0]      load_key,
    output logic [KEY_BITS-1:0]      key_out,
    output ske_pkg::cell_flags_t     flags
);

    logic [KEY_BITS-1:0]  key_reg;
    logic [KEY_BITS-1:0]  key_next;
    ske_pkg::cell_flags_t flags_reg;
    ske_pkg::cell_flags_t flags_next;
    logic                 live;

    // Only cells below the fill count hold a key of the set.
    assign live = CNT_W'(IDX) < count;

    always_comb
    begin
        flags_next.lt_key = live && (key_reg < cmp_key);
        flags_next.eq_key = live && (key_reg == cmp_key);
        flags_next.lt_new = live && (key_reg < cmp_new);
        flags_next.eq_new = live && (key_reg == cmp_new);
    end

    always_comb
    begin
        case (op)
            ske_pkg::OP_FROM_LEFT:  key_next = left_key;
            ske_pkg::OP_FROM_RIGHT: key_next = right_key;
            ske_pkg::OP_LOAD:       key_next = load_key;
            default:                key_next = key_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (sample)
        begin
            flags_reg <= flags_next;
        end
    end

    assign key_out = key_reg;
    assign flags   = flags_reg;

endmodule

`default_nettype wire

// File: src/ske_encode.sv
// Turns the row of less-than flags into the lower-bound index and ORs the
// equal flags into a hit. Depends on ske_pkg for the default capacity.
`timescale 1ns / 1ps
`default_nettype none

module ske_encode #(
    parameter int CAPACITY = ske_pkg::CAPACITY_DEF,
    parameter int CNT_W    = 11
) (
    input  wire  [CAPACITY-1:0] lt_vec,
    input  wire  [CAPACITY-1:0] eq_vec,
    output logic [CNT_W-1:0]    pos,
    output logic                hit
);

    logic [CAPACITY-1:0] edge_vec;

    // The flags form a run of ones from cell 0; the index is one past the last one.
    assign edge_vec = lt_vec & ~({1'b0, lt_vec[CAPACITY-1:1]});

    always_comb
    begin
        pos = '0;
        for (int m = 0; m < CAPACITY; m++)
        begin
            if (edge_vec[m])
            begin
                pos = pos | CNT_W'(m + 1);
            end
        end
    end

    assign hit = |eq_vec;

endmodule

`default_nettype wire
